@@ sv/arpc_pkg.sv @@
// arpc_pkg: table size, command and status codes, and the table entry layout
// for the address resolution cache. No dependencies.
package arpc_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [15:0] AgeLimitReset = 16'd10;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_EXPIRED   = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_INSERTED  = 3'd4,
    ST_FULL      = 3'd5,
    ST_REFRESHED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

@@ sv/arpc_if.sv @@
// arpc_if: valid/ready channel interfaces for requests, responses and the
// age limit write port. No dependencies.
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] ip_address;
  logic [47:0] hardware_address;
  logic [31:0] now_seconds;
  modport source (output valid, command, ip_address, hardware_address, now_seconds,
                  input ready);
  modport sink   (input valid, command, ip_address, hardware_address, now_seconds,
                  output ready);
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [47:0] found_mac;
  logic [2:0]  status;
  modport source (output valid, hit, found_mac, status, input ready);
  modport sink   (input valid, hit, found_mac, status, output ready);
endinterface

interface arpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] age_limit_seconds;
  modport source (output valid, age_limit_seconds, input ready);
  modport sink   (input valid, age_limit_seconds, output ready);
endinterface

@@ sv/arp_cache_aging_table_unit.sv @@
// arp_cache_aging_table_unit: ip to mac resolution table with age-out.
// Depends on arpc_pkg and the channel interfaces in arpc_if.sv.
//
// One request beat in, one response beat out. The table sits in a single
// synchronous memory of TableEntries words (ip, mac, stamp) with a registered
// read; valid bits are flip-flops cleared by reset. Every lookup, update and
// refresh walks the memory from entry 0, one read per clock, so the memory's
// single read port sets the timing: a lookup or update that matches an entry
// ends its walk there, a miss, insert, table full or refresh walks the whole
// table, and an unused command code answers a miss without a walk. The block
// takes one request at a time; a new request beat is taken as soon as the
// previous response is parked in the output register, even if the sink has
// not taken it yet. The age limit is written through its own channel (always
// ready, reset value 10) and must only be written while the block is idle.
module arp_cache_aging_table_unit import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  arpc_cfg_if.sink    cfg_i,
  arpc_req_if.sink    req_i,
  arpc_rsp_if.source  rsp_o
);

  state_e state_q, state_d;

  // captured request
  logic [1:0]  cmd_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [31:0] now_q;
  logic [15:0] age_limit_q;

  // table storage
  entry_t                  mem_q [TableEntries];
  entry_t                  rdata_q;
  logic [TableEntries-1:0] valid_q, valid_d;

  // scan pointer and read pipeline
  logic [CntW-1:0] addr_q, addr_d;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_vld_q, rd_vld_d;
  logic            rd_en;

  // first free slot seen so far
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  // memory write port
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_data;

  // response being built, and the output register
  logic        res_hit_q, res_hit_d;
  logic [47:0] res_mac_q, res_mac_d;
  status_e     res_status_q, res_status_d;
  logic        out_valid_q, out_valid_d;
  logic        out_hit_q;
  logic [47:0] out_mac_q;
  status_e     out_status_q;

  logic        req_fire;
  logic        out_load;
  logic        scan_done;
  logic        cur_valid;
  logic        cur_match;
  logic        is_last;
  logic [31:0] age;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.found_mac = out_mac_q;
  assign rsp_o.status    = out_status_q;

  // entry whose read data is in rdata_q this cycle
  assign cur_valid = valid_q[rd_idx_q];
  assign cur_match = rd_vld_q && cur_valid && (rdata_q.ip == ip_q);
  assign is_last   = (rd_idx_q == IdxW'(TableEntries - 1));
  assign age       = now_q - rdata_q.stamp;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.command == CMD_LOOKUP || req_i.command == CMD_UPDATE ||
              req_i.command == CMD_REFRESH) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // scan datapath and outputs
  always_comb begin
    valid_d      = valid_q;
    addr_d       = addr_q;
    rd_vld_d     = 1'b0;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    wr_en        = 1'b0;
    wr_idx       = rd_idx_q;
    wr_data      = '{ip: ip_q, mac: mac_q, stamp: now_q};
    res_hit_d    = res_hit_q;
    res_mac_d    = res_mac_q;
    res_status_d = res_status_q;
    scan_done    = 1'b0;
    out_load     = 1'b0;

    // read issue: one entry per clock until the whole table has been asked for
    rd_en = (state_q == S_SCAN) && (addr_q < CntW'(TableEntries));
    if (rd_en) begin
      addr_d   = addr_q + CntW'(1);
      rd_vld_d = 1'b1;
    end

    if (req_fire) begin
      // default answer is a miss, also for the unused command code
      addr_d       = '0;
      free_found_d = 1'b0;
      res_hit_d    = 1'b0;
      res_mac_d    = '0;
      res_status_d = ST_MISS;
    end

    if (state_q == S_SCAN && rd_vld_q) begin
      case (cmd_q)
        CMD_LOOKUP: begin
          if (cur_match) begin
            scan_done = 1'b1;
            if (age > {16'h0, age_limit_q}) begin
              valid_d[rd_idx_q] = 1'b0;
              res_status_d      = ST_EXPIRED;
            end else begin
              res_hit_d    = 1'b1;
              res_mac_d    = rdata_q.mac;
              res_status_d = ST_HIT;
            end
          end else if (is_last) begin
            scan_done = 1'b1;
          end
        end
        CMD_UPDATE: begin
          if (cur_match) begin
            // rewrite mac and stamp in place
            wr_en        = 1'b1;
            scan_done    = 1'b1;
            res_status_d = ST_UPDATED;
          end else begin
            if (!cur_valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = rd_idx_q;
            end
            if (is_last) begin
              scan_done = 1'b1;
              if (free_found_q || !cur_valid) begin
                wr_en           = 1'b1;
                wr_idx          = free_found_q ? free_idx_q : rd_idx_q;
                valid_d[wr_idx] = 1'b1;
                res_status_d    = ST_INSERTED;
              end else begin
                res_status_d = ST_FULL;
              end
            end
          end
        end
        CMD_REFRESH: begin
          // read-modify-write of the stamp; the next read is a different entry
          if (cur_valid) begin
            wr_en   = 1'b1;
            wr_data = '{ip: rdata_q.ip, mac: rdata_q.mac, stamp: now_q};
          end
          if (is_last) begin
            scan_done    = 1'b1;
            res_status_d = ST_REFRESHED;
          end
        end
        default: begin
          scan_done = 1'b1;
        end
      endcase
    end

    // park the response once the output register is free
    if (state_q == S_DONE && (!out_valid_q || rsp_o.ready)) begin
      out_load = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // table memory, one write and one registered read per clock
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_data;
    if (rd_en) rdata_q <= mem_q[addr_q[IdxW-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      addr_q       <= '0;
      rd_vld_q     <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      age_limit_q  <= AgeLimitReset;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      addr_q       <= addr_d;
      rd_vld_q     <= rd_vld_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_i.valid) age_limit_q <= cfg_i.age_limit_seconds;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= req_i.command;
      ip_q  <= req_i.ip_address;
      mac_q <= req_i.hardware_address;
      now_q <= req_i.now_seconds;
    end
    rd_idx_q     <= addr_q[IdxW-1:0];
    free_idx_q   <= free_idx_d;
    res_hit_q    <= res_hit_d;
    res_mac_q    <= res_mac_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_hit_q    <= res_hit_q;
      out_mac_q    <= res_mac_q;
      out_status_q <= res_status_q;
    end
  end

endmodule

@@ sv/arpc_checker.sv @@
// arpc_checker: port-level checks on the response channel of the resolution
// table, bound to arp_cache_aging_table_unit. Depends on arpc_pkg.
module arpc_checker import arpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_hit,
  input logic [47:0] rsp_found_mac,
  input logic [2:0]  rsp_status
);

  // no response beat offered while in reset
  a_no_rsp_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid)
    else $error("response valid during reset");

  // hit flag agrees with the hit status
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_hit == (rsp_status == ST_HIT)))
    else $error("hit flag and status disagree");

  // mac only returned on a hit
  a_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_hit) |-> (rsp_found_mac == 48'h0))
    else $error("mac returned without a hit");

  // status code is one of the defined ones
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_status <= 3'(ST_REFRESHED)))
    else $error("unused status code");

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_found_mac) && $stable(rsp_status)))
    else $error("stalled response changed");

endmodule

bind arp_cache_aging_table_unit arpc_checker u_arpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .rsp_hit       (rsp_o.hit),
  .rsp_found_mac (rsp_o.found_mac),
  .rsp_status    (rsp_o.status)
);
